// ===== rtl/rcbe_pkg.sv =====
// Package for the row change bitmap encoder.
// Holds widths, configuration register indexes, controller states and the
// command/status structs shared by the controller and the datapath.
package rcbe_pkg;

  localparam int unsigned MaxRowLengthDef = 128;
  localparam int unsigned GroupSize       = 32;
  localparam int unsigned SlotW           = $clog2(GroupSize);
  localparam int unsigned WordW           = 32;
  localparam int unsigned RowLenW         = 8;
  localparam int unsigned RowCntW         = 16;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = RowCntW;

  localparam logic [CfgIdxW-1:0] CfgRowLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRowCount  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_BITMAP,
    ST_FETCH,
    ST_VALUE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic load_bitmap;
    logic fetch;
    logic load_value;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close;
    logic drain_empty;
    logic out_free;
  } dp_status_t;

  // Index of the lowest set bit of a group mask (zero when the mask is empty).
  function automatic logic [SlotW-1:0] lowest_set(input logic [GroupSize-1:0] m);
    logic [GroupSize-1:0] onehot;
    logic [SlotW-1:0]     idx;
    logic [GroupSize-1:0] sel;
    onehot = m & (~m + GroupSize'(1));
    for (int b = 0; b < SlotW; b++) begin
      for (int i = 0; i < GroupSize; i++) begin
        sel[i] = ((i >> b) & 1) == 1;
      end
      idx[b] = |(onehot & sel);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/rcbe_stream_if.sv =====
// Stream interfaces of the row change bitmap encoder: entry input and word output.
// Depends on rcbe_pkg for the word width.
interface rcbe_in_if
  import rcbe_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] entry_value;

  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

interface rcbe_out_if
  import rcbe_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] out_word;
  logic                    is_bitmap;
  logic                    last;

  modport source (output valid, output out_word, output is_bitmap, output last, input ready);
  modport sink   (input valid, input out_word, input is_bitmap, input last, output ready);
endinterface

// ===== rtl/row_change_bitmap_encoder.sv =====
// Top level of the row change bitmap encoder.
// Depends on rcbe_pkg, rcbe_stream_if, rcbe_ctrl and rcbe_dp.
//
//   channel   direction  payload                          handshake
//   in_if     sink       entry_value[31:0] (signed)       valid/ready
//   out_if    source     out_word[31:0], is_bitmap, last  valid/ready
//   cfg       write      cfg_idx_i[0], cfg_data_i[15:0]   cfg_we_i, no wait
//
// One request is taken at a time. A request that does not close a group passes
// through accept with a previous-row read, then compare and update.
// A closing request adds a bitmap load and, per changed value, a group-value
// memory read and an output load. Output stalls hold the sequencer.
// The output register lets a finished word wait while the next request is taken.
// Reset clears the counters, the change mask and the output valid; the memories
// are left as they are and are written before their contents are used.
module row_change_bitmap_encoder
  import rcbe_pkg::*;
#(
  parameter int unsigned MAX_ROW_LENGTH = MaxRowLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rcbe_in_if.sink             in_if,
  rcbe_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: accept, compare, then drain bitmap and changed values
  rcbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage, counters and the output register
  rcbe_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .entry_value_i   (in_if.entry_value),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_if.valid),
    .out_word_o      (out_if.out_word),
    .out_is_bitmap_o (out_if.is_bitmap),
    .out_last_o      (out_if.last),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// ===== rtl/rcbe_ctrl.sv =====
// Controller state machine of the row change bitmap encoder.
// Depends on rcbe_pkg; drives dp_cmd_t and reads dp_status_t.
module rcbe_ctrl
  import rcbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = status_i.close ? ST_BITMAP : ST_IDLE;
      end
      ST_BITMAP, ST_VALUE: begin
        if (status_i.out_free) state_d = status_i.drain_empty ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_VALUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOKUP: cmd_o.update      = 1'b1;
      ST_BITMAP: cmd_o.load_bitmap = status_i.out_free;
      ST_FETCH:  cmd_o.fetch       = 1'b1;
      ST_VALUE:  cmd_o.load_value  = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rcbe_dp.sv =====
// Datapath of the row change bitmap encoder: config registers, previous-row and
// group-value memories, change mask, row/column counters and output register.
// Depends on rcbe_pkg; commanded by rcbe_ctrl.
module rcbe_dp
  import rcbe_pkg::*;
#(
  parameter int unsigned MAX_ROW_LENGTH = MaxRowLengthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic signed [WordW-1:0] entry_value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [WordW-1:0] out_word_o,
  output logic                    out_is_bitmap_o,
  output logic                    out_last_o,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o
);

  localparam int unsigned ColW  = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int unsigned LenW0 = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned LenW  = ((LenW0 > RowLenW) ? LenW0 : RowLenW) + 1;

  logic [RowLenW-1:0]   row_len_q;
  logic [RowCntW-1:0]   row_cnt_q;
  logic [ColW-1:0]      col_q;
  logic [RowCntW-1:0]   row_q;
  logic [WordW-1:0]     val_q;
  logic [GroupSize-1:0] mask_q;
  logic [GroupSize-1:0] bitmap_q;
  logic [GroupSize-1:0] drain_q;
  logic [WordW-1:0]     prev_rd_q;
  logic [WordW-1:0]     grp_rd_q;
  logic                 out_valid_q;
  logic [WordW-1:0]     out_word_q;
  logic                 out_bitmap_q;
  logic                 out_last_q;

  logic [WordW-1:0] prev_mem [MAX_ROW_LENGTH];
  logic [WordW-1:0] grp_mem  [GroupSize];

  logic [LenW-1:0]      len_ext, eff_len, col_ext, col_c;
  logic [RowCntW-1:0]   eff_cnt;
  logic [RowCntW:0]     row_inc;
  logic                 row_end, changed, close;
  logic [SlotW-1:0]     slot, fetch_idx;
  logic [GroupSize-1:0] slot_bit, mask_new, low_mask;

  // Effective length and count; position clamped into the current row
  always_comb begin
    len_ext  = LenW'(row_len_q);
    if (row_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > LenW'(MAX_ROW_LENGTH)) begin
      eff_len = LenW'(MAX_ROW_LENGTH);
    end else begin
      eff_len = len_ext;
    end
    eff_cnt  = (row_cnt_q == '0) ? RowCntW'(1) : row_cnt_q;
    col_ext  = LenW'(col_q);
    row_end  = (col_ext + LenW'(1)) >= eff_len;
    col_c    = (col_ext >= eff_len) ? (eff_len - LenW'(1)) : col_ext;
    slot     = col_c[SlotW-1:0];
    slot_bit = GroupSize'(1) << slot;
    low_mask = (slot_bit << 1) - GroupSize'(1);
    changed  = (row_q == '0) || (prev_rd_q != val_q);
    mask_new = mask_q | (changed ? slot_bit : '0);
    close    = row_end || (slot == SlotW'(GroupSize - 1));
    row_inc  = {1'b0, row_q} + (RowCntW + 1)'(1);
    fetch_idx = lowest_set(drain_q);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= RowLenW'(1);
      row_cnt_q   <= RowCntW'(1);
      col_q       <= '0;
      row_q       <= '0;
      mask_q      <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRowLength: row_len_q <= cfg_data_i[RowLenW-1:0];
          CfgRowCount:  row_cnt_q <= cfg_data_i[RowCntW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        mask_q <= close ? '0 : mask_new;
        if (close) drain_q <= mask_new & low_mask;
        if (row_end) begin
          col_q <= '0;
          row_q <= (row_inc >= {1'b0, eff_cnt}) ? '0 : row_inc[RowCntW-1:0];
        end else begin
          col_q <= ColW'(col_c + LenW'(1));
        end
      end else if (cmd_i.fetch) begin
        drain_q <= drain_q & (drain_q - GroupSize'(1));
      end
      if (cmd_i.load_bitmap || cmd_i.load_value) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q     <= entry_value_i;
      prev_rd_q <= prev_mem[col_c[ColW-1:0]];
    end
    if (cmd_i.update) begin
      prev_mem[col_c[ColW-1:0]] <= val_q;
      grp_mem[slot]             <= val_q;
      if (close) bitmap_q <= mask_new;
    end
    if (cmd_i.fetch) begin
      grp_rd_q <= grp_mem[fetch_idx];
    end
    if (cmd_i.load_bitmap) begin
      out_word_q   <= bitmap_q;
      out_bitmap_q <= 1'b1;
      out_last_q   <= (drain_q == '0);
    end else if (cmd_i.load_value) begin
      out_word_q   <= grp_rd_q;
      out_bitmap_q <= 1'b0;
      out_last_q   <= (drain_q == '0);
    end
  end

  assign status_o.close       = close;
  assign status_o.drain_empty = (drain_q == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;
  assign out_is_bitmap_o = out_bitmap_q;
  assign out_last_o      = out_last_q;

endmodule

// ===== rtl/rcbe_checker.sv =====
// Port-level checks for the row change bitmap encoder, bound to the top level.
// Depends on rcbe_pkg for the word width.
module rcbe_checker
  import rcbe_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [WordW-1:0] out_word_i,
  input logic             out_is_bitmap_i,
  input logic             out_last_i
);

  logic pending_q;  // a group has started draining and its last word is not out yet

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      pending_q <= !out_last_i;
    end
  end

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled output word changed");

  // A group opens with its bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !pending_q |-> out_is_bitmap_i)
    else $error("group did not open with a bitmap");

  // Only values follow a bitmap within a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && pending_q |-> !out_is_bitmap_i)
    else $error("bitmap inside a group drain");

  // Hold the flags of a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_is_bitmap_i) && $stable(out_last_i))
    else $error("stalled output flags changed");

endmodule

bind row_change_bitmap_encoder rcbe_checker u_rcbe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_word_i      (out_if.out_word),
  .out_is_bitmap_i (out_if.is_bitmap),
  .out_last_i      (out_if.last)
);
